// File: rtl/core/motor_stall_fault_monitor_defines.svh
// Assertion macros used by the checker file.
`ifndef MOTOR_STALL_FAULT_MONITOR_DEFINES_SVH
`define MOTOR_STALL_FAULT_MONITOR_DEFINES_SVH

// Clocked property, ignored while reset is held
`define MSFM_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("msfm assertion failed");

// Clocked property that must also hold through reset
`define MSFM_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("msfm assertion failed");

`endif

// File: rtl/core/msfm_pkg.sv
package msfm_pkg;

    // Reported machine status
    typedef enum logic [1:0] {
        ST_DISABLED = 2'd0,
        ST_RUNNING  = 2'd1,
        ST_WARNING  = 2'd2,
        ST_FAULT    = 2'd3
    } status_t;

    // Latched fault reason
    typedef enum logic [2:0] {
        FK_NONE   = 3'd0,
        FK_SENSOR = 3'd1,
        FK_STALL  = 3'd2,
        FK_INPUT  = 3'd3,
        FK_CONFIG = 3'd4
    } fault_t;

    // Controller status codes; anything above CS_CONFIG_FAULT is invalid
    localparam logic [2:0] CS_RUNNING      = 3'd0;
    localparam logic [2:0] CS_DISABLED     = 3'd1;
    localparam logic [2:0] CS_INPUT_FAULT  = 3'd2;
    localparam logic [2:0] CS_CONFIG_FAULT = 3'd3;

    // Configuration register map
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 24;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_TARGET  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_RATIO = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_DUTY    = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CONFIRM     = 4'd3;

    localparam int CONFIRM_W = 24;
    localparam int PROD_W    = 25;

    // Register reset values
    localparam logic [15:0]          RST_MIN_TARGET  = 16'd1000;
    localparam logic [8:0]           RST_SPEED_RATIO = 9'd64;
    localparam logic [9:0]           RST_MIN_DUTY    = 10'd700;
    localparam logic [CONFIRM_W-1:0] RST_CONFIRM     = 24'd750000;

    // Stream widths
    localparam int S_TDATA_W = 64;
    localparam int S_TUSER_W = 4;
    localparam int M_TDATA_W = 8;

    typedef struct packed {
        logic [2:0]  ctrl_status;
        logic        adc_reason;
        logic [15:0] cmd_speed;
        logic [15:0] act_speed;
        logic [9:0]  duty_permille;
        logic        run_req;
        logic [15:0] sample_us;
    } sample_t;

    typedef struct packed {
        logic [15:0]          min_cmd_speed;
        logic [8:0]           speed_ratio_q8;
        logic [9:0]           min_duty_permille;
        logic [CONFIRM_W-1:0] confirm_time_us;
    } cfg_t;

    typedef struct packed {
        status_t machine_status;
        fault_t  fault_kind;
        logic    stop_req;
    } result_t;

endpackage

// File: rtl/core/motor_stall_fault_monitor.sv
// Motor stall fault monitor. Takes one control-loop sample per word on the s_ stream and
// returns one status word per sample on the m_ stream, in order: one word per clock
// sustained while m_tready stays high (input register, then the evaluation that loads the
// output register; the stall timer and fault latch are committed as each sample moves on).
// A fault (sensor, input, configuration or confirmed stall) latches with stop_req set
// and holds until rst_n. Registers on the cfg_ port take effect for the next sample and
// are to be written only while no sample is in flight; the block does not enforce this.
module motor_stall_fault_monitor
    import msfm_pkg::*;
#(
    parameter int TIMER_BITS = 24
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [15:0] cmd_speed, [31:16] act_speed, [41:32] duty_permille,
    // [42] run_req, [58:43] sample_us, [63:59] zero
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // [2:0] ctrl_status, [3] adc_reason
    input  logic [S_TUSER_W-1:0]  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [1:0] machine_status, [4:2] fault_kind, [5] stop_req, [7:6] zero
    output logic [M_TDATA_W-1:0]  m_tdata,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    sample_t sample_in;
    sample_t in_data_reg;
    logic    in_valid_reg;
    logic    in_valid_next;
    result_t out_res_reg;
    logic    out_valid_reg;
    logic    out_valid_next;
    result_t step_res;
    cfg_t    cfg;
    logic    advance;

    // Unpack the incoming word
    assign sample_in.ctrl_status   = s_tuser[2:0];
    assign sample_in.adc_reason    = s_tuser[3];
    assign sample_in.cmd_speed     = s_tdata[15:0];
    assign sample_in.act_speed     = s_tdata[31:16];
    assign sample_in.duty_permille = s_tdata[41:32];
    assign sample_in.run_req       = s_tdata[42];
    assign sample_in.sample_us     = s_tdata[58:43];

    msfm_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    msfm_step #(
        .TIMER_BITS (TIMER_BITS)
    ) u_step (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (advance),
        .smp     (in_data_reg),
        .cfg     (cfg),
        .res     (step_res)
    );

    // Advance when the output register is free or being drained
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    // Hold valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Load payload registers
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            in_data_reg <= sample_in;
        if (advance)
            out_res_reg <= step_res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_res_reg.stop_req, out_res_reg.fault_kind,
                       out_res_reg.machine_status};

endmodule

// File: rtl/core/msfm_cfg_regs.sv
module msfm_cfg_regs
    import msfm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    logic [15:0]          min_target_reg;
    logic [8:0]           speed_ratio_reg;
    logic [9:0]           min_duty_reg;
    logic [CONFIRM_W-1:0] confirm_reg;

    // Writes are always taken
    assign cfg_ready = 1'b1;

    // Decode the index and load the addressed register; ignore unknown indexes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_target_reg  <= RST_MIN_TARGET;
            speed_ratio_reg <= RST_SPEED_RATIO;
            min_duty_reg    <= RST_MIN_DUTY;
            confirm_reg     <= RST_CONFIRM;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_MIN_TARGET:  min_target_reg  <= cfg_data[15:0];
                REG_SPEED_RATIO: speed_ratio_reg <= cfg_data[8:0];
                REG_MIN_DUTY:    min_duty_reg    <= cfg_data[9:0];
                REG_CONFIRM:     confirm_reg     <= cfg_data[CONFIRM_W-1:0];
                default:         ;
            endcase
        end
    end

    assign cfg.min_cmd_speed     = min_target_reg;
    assign cfg.speed_ratio_q8    = speed_ratio_reg;
    assign cfg.min_duty_permille = min_duty_reg;
    assign cfg.confirm_time_us   = confirm_reg;

endmodule

// File: rtl/core/msfm_step.sv
module msfm_step
    import msfm_pkg::*;
#(
    parameter int TIMER_BITS = 24
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    step_en,
    input  sample_t smp,
    input  cfg_t    cfg,
    output result_t res
);

    localparam int SUM_W = TIMER_BITS + 1;
    localparam int CMP_W = (TIMER_BITS > CONFIRM_W) ? TIMER_BITS : CONFIRM_W;

    fault_t                fault_reg;
    fault_t                fault_next;
    logic [TIMER_BITS-1:0] timer_reg;
    logic [TIMER_BITS-1:0] timer_next;
    logic                  stop_reg;
    logic                  stop_next;
    status_t               status;

    logic [PROD_W-1:0]     speed_limit;
    logic [PROD_W-1:0]     meas_scaled;
    logic                  stall;
    logic [SUM_W-1:0]      timer_sum;
    logic [TIMER_BITS-1:0] timer_sat;
    logic                  confirmed;

    // Stall suspicion: measured * 256 <= target * ratio, plus target and duty floors
    assign speed_limit = PROD_W'(smp.cmd_speed) * PROD_W'(cfg.speed_ratio_q8);
    assign meas_scaled = {1'b0, smp.act_speed, 8'b0};
    assign stall = (smp.cmd_speed >= cfg.min_cmd_speed)
                && (meas_scaled <= speed_limit)
                && (smp.duty_permille >= cfg.min_duty_permille);

    // Accumulate sample time, saturating at the timer's full scale
    assign timer_sum = {1'b0, timer_reg} + SUM_W'(smp.sample_us);
    assign timer_sat = timer_sum[TIMER_BITS] ? {TIMER_BITS{1'b1}}
                                             : timer_sum[TIMER_BITS-1:0];
    assign confirmed = CMP_W'(timer_sat) >= CMP_W'(cfg.confirm_time_us);

    // Evaluate one sample against the latched state
    always_comb
    begin
        fault_next = fault_reg;
        timer_next = timer_reg;
        stop_next  = stop_reg;
        status     = ST_DISABLED;
        if (fault_reg != FK_NONE)
        begin
            status = ST_FAULT;
        end
        else if (smp.ctrl_status == CS_INPUT_FAULT)
        begin
            fault_next = smp.adc_reason ? FK_SENSOR : FK_INPUT;
            stop_next  = 1'b1;
            status     = ST_FAULT;
        end
        else if ((smp.ctrl_status > CS_INPUT_FAULT) || (smp.sample_us == '0))
        begin
            // config fault, invalid status codes and a zero sample period
            fault_next = FK_CONFIG;
            stop_next  = 1'b1;
            status     = ST_FAULT;
        end
        else if (!smp.run_req || (smp.ctrl_status == CS_DISABLED))
        begin
            timer_next = '0;
            status     = ST_DISABLED;
        end
        else if (!stall)
        begin
            timer_next = '0;
            status     = ST_RUNNING;
        end
        else
        begin
            timer_next = timer_sat;
            if (confirmed)
            begin
                fault_next = FK_STALL;
                stop_next  = 1'b1;
                status     = ST_FAULT;
            end
            else
            begin
                status = ST_WARNING;
            end
        end
    end

    assign res.machine_status = status;
    assign res.fault_kind     = (status == ST_FAULT) ? fault_next : FK_NONE;
    assign res.stop_req       = stop_next;

    // Commit the state when the sample moves to the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fault_reg <= FK_NONE;
            timer_reg <= '0;
            stop_reg  <= 1'b0;
        end
        else if (step_en)
        begin
            fault_reg <= fault_next;
            timer_reg <= timer_next;
            stop_reg  <= stop_next;
        end
    end

endmodule

// File: rtl/core/msfm_checker.sv
`include "motor_stall_fault_monitor_defines.svh"

module msfm_checker
    import msfm_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    logic seen_stop_reg;
    logic seen_stop_next;
    logic is_fault;

    assign is_fault       = (m_tdata[1:0] == ST_FAULT);
    assign seen_stop_next = seen_stop_reg || (m_tvalid && m_tready && m_tdata[5]);

    // Remember that a stop request has been delivered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seen_stop_reg <= 1'b0;
        else
            seen_stop_reg <= seen_stop_next;
    end

    // A fault kind is shown exactly when the status is fault
    `MSFM_ASSERT_ALWAYS(a_kind_matches_status,
        m_tvalid |-> (is_fault == (m_tdata[4:2] != FK_NONE)))
    // A stop request comes only with a fault status
    `MSFM_ASSERT(a_stop_needs_fault, (m_tvalid && m_tdata[5]) |-> is_fault)
    // Once a stop has gone out, every later word keeps it
    `MSFM_ASSERT(a_stop_sticks, (m_tvalid && seen_stop_reg) |-> (m_tdata[5] && is_fault))
    // A stalled word holds its data
    `MSFM_ASSERT(a_hold_when_stalled, (m_tvalid && !m_tready) |=> $stable(m_tdata))

endmodule

bind motor_stall_fault_monitor msfm_checker u_msfm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
